>>> sv/ble_pkg.sv
// shared widths, register indexes and reset values of the battery level estimator
package ble_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 12;
  localparam int PCT_W      = 7;
  localparam int GAIN_W     = 20;
  localparam int OFFSET_W   = 16;
  localparam int THR_W      = 12;
  localparam int GAIN_FRAC  = 16;
  localparam int PROD_W     = GAIN_W + LEVEL_W;
  localparam int SCALED_W   = PROD_W - GAIN_FRAC;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR   = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 20'd19360;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd300;
  localparam logic [THR_W-1:0]    THR_RST    = 12'd10;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

endpackage

>>> sv/ble_if.sv
// handshake channels of the battery level estimator: samples, reports and register writes
interface ble_in_if import ble_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ble_out_if import ble_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PCT_W-1:0]   percent;
  logic [LEVEL_W-1:0] filtered_level;

  modport source (output valid, output percent, output filtered_level, input ready);
  modport sink   (input valid, input percent, input filtered_level, output ready);
endinterface

interface ble_cfg_if import ble_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/battery_level_estimator.sv
// battery level estimator: takes one converter sample per cycle; every BLOCK_LEN samples the
// block mean enters a WINDOW_LEN-entry moving average, and a percent report follows when the
// filtered level moves by more than change_threshold (or the previous level was zero). The
// pipeline runs eight stages from the accepting edge to the output register. All stages
// advance together whenever the output register is empty or being drained, so a sample is
// taken every cycle unless a report sits unread. Register writes are always taken.
module battery_level_estimator import ble_pkg::*; #(
  parameter int WINDOW_LEN = 10,
  parameter int BLOCK_LEN  = 10
) (
  input logic      clk,
  input logic      rst_n,
  ble_in_if.sink   in_chan,
  ble_out_if.source out_chan,
  ble_cfg_if.sink  cfg_chan
);

  localparam int BSUM_W = $clog2(BLOCK_LEN * (2 ** SAMPLE_W));
  localparam int WSUM_W = $clog2(WINDOW_LEN * (2 ** LEVEL_W));
  localparam int CNT_W  = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int PTR_W  = $clog2(WINDOW_LEN);
  // reciprocals rounded down; one correction step restores the exact quotient
  localparam logic [BSUM_W:0] BLK_M = (BSUM_W+1)'((1 << BSUM_W) / BLOCK_LEN);
  localparam logic [WSUM_W:0] WIN_M = (WSUM_W+1)'((1 << WSUM_W) / WINDOW_LEN);

  // configuration
  logic [GAIN_W-1:0]   gain_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [THR_W-1:0]    thr_r;

  // state
  logic [BSUM_W-1:0]  block_sum_r;
  logic [CNT_W-1:0]   block_count_r;
  logic [LEVEL_W-1:0] window_r [WINDOW_LEN];
  logic [WSUM_W-1:0]  window_sum_r;
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [LEVEL_W-1:0] prev_level_r;

  // pipeline
  logic               s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic [BSUM_W-1:0]  s1_total_r, s2_total_r;
  logic [LEVEL_W-1:0] s2_q_r, s3_mean_r;
  logic [WSUM_W-1:0]  s4_wsum_r, s5_wsum_r;
  logic [LEVEL_W-1:0] s5_q_r, s6_level_r, s7_level_r;
  logic [PROD_W-1:0]  s7_prod_r;
  logic               out_valid_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic                   adv, acc;
  logic [BSUM_W-1:0]      blk_total;
  logic                   blk_last;
  logic [2*BSUM_W:0]      blk_prod;
  logic [BSUM_W-1:0]      blk_qd, blk_rem;
  logic [LEVEL_W-1:0]     blk_mean;
  logic [WSUM_W-1:0]      win_sum_nxt;
  logic [PTR_W-1:0]       wr_ptr_nxt;
  logic [2*WSUM_W:0]      win_prod;
  logic [WSUM_W-1:0]      win_qd, win_rem;
  logic [LEVEL_W-1:0]     level, lvl_diff;
  logic                   report;
  logic [PROD_W-1:0]      prod_nxt;
  logic [SCALED_W-1:0]    scaled, pct_diff;
  logic [PCT_W-1:0]       pct_nxt;

  assign adv            = !out_valid_r || out_chan.ready;
  assign acc            = in_chan.valid && adv;
  assign in_chan.ready  = adv;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.percent        = out_pct_r;
  assign out_chan.filtered_level = out_level_r;

  // block accumulation
  assign blk_total = block_sum_r + BSUM_W'(in_chan.sample);
  assign blk_last  = (block_count_r == CNT_W'(BLOCK_LEN - 1));

  // block mean: estimate, then correct by one
  assign blk_prod = (2*BSUM_W+1)'(s1_total_r) * (2*BSUM_W+1)'(BLK_M);
  assign blk_qd   = BSUM_W'(s2_q_r) * BSUM_W'(BLOCK_LEN);
  assign blk_rem  = s2_total_r - blk_qd;
  assign blk_mean = s2_q_r + LEVEL_W'(blk_rem >= BSUM_W'(BLOCK_LEN));

  // window update with running sum
  assign win_sum_nxt = window_sum_r - WSUM_W'(window_r[wr_ptr_r]) + WSUM_W'(s3_mean_r);
  assign wr_ptr_nxt  = (wr_ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : wr_ptr_r + 1'b1;

  // window mean and change test
  assign win_prod = (2*WSUM_W+1)'(s4_wsum_r) * (2*WSUM_W+1)'(WIN_M);
  assign win_qd   = WSUM_W'(s5_q_r) * WSUM_W'(WINDOW_LEN);
  assign win_rem  = s5_wsum_r - win_qd;
  assign level    = s5_q_r + LEVEL_W'(win_rem >= WSUM_W'(WINDOW_LEN));
  assign lvl_diff = (level > prev_level_r) ? level - prev_level_r : prev_level_r - level;
  assign report   = (prev_level_r == '0) || (lvl_diff > thr_r);

  // scaling and clamp
  assign prod_nxt = PROD_W'(gain_r) * PROD_W'(s6_level_r);
  assign scaled   = s7_prod_r[PROD_W-1:GAIN_FRAC];
  assign pct_diff = scaled - SCALED_W'(offset_r);

  always_comb begin
    priority if (scaled < SCALED_W'(offset_r)) begin
      pct_nxt = '0;
    end else if (pct_diff > SCALED_W'(PCT_MAX)) begin
      pct_nxt = PCT_MAX;
    end else begin
      pct_nxt = pct_diff[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      offset_r <= OFFSET_RST;
      thr_r    <= THR_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_SCALE_GAIN:   gain_r   <= cfg_chan.data[GAIN_W-1:0];
        CFG_EMPTY_OFFSET: offset_r <= cfg_chan.data[OFFSET_W-1:0];
        CFG_CHANGE_THR:   thr_r    <= cfg_chan.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_sum_r   <= '0;
      block_count_r <= '0;
      window_sum_r  <= '0;
      wr_ptr_r      <= '0;
      prev_level_r  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_r[i] <= '0;
      end
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      s7_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (acc) begin
        if (blk_last) begin
          block_sum_r   <= '0;
          block_count_r <= '0;
        end else begin
          block_sum_r   <= blk_total;
          block_count_r <= block_count_r + 1'b1;
        end
      end
      if (s3_vld_r) begin
        window_r[wr_ptr_r] <= s3_mean_r;
        window_sum_r       <= win_sum_nxt;
        wr_ptr_r           <= wr_ptr_nxt;
      end
      // previous level follows every completed block, reported or not
      if (s5_vld_r) begin
        prev_level_r <= level;
      end
      s1_vld_r    <= acc && blk_last;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r && report;
      s7_vld_r    <= s6_vld_r;
      out_valid_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_total_r  <= blk_total;
      s2_total_r  <= s1_total_r;
      s2_q_r      <= blk_prod[BSUM_W +: LEVEL_W];
      s3_mean_r   <= blk_mean;
      s4_wsum_r   <= win_sum_nxt;
      s5_wsum_r   <= s4_wsum_r;
      s5_q_r      <= win_prod[WSUM_W +: LEVEL_W];
      s6_level_r  <= level;
      s7_level_r  <= s6_level_r;
      s7_prod_r   <= prod_nxt;
      out_pct_r   <= pct_nxt;
      out_level_r <= s7_level_r;
    end
  end

endmodule

>>> tb/ble_level_checker.sv
// report predictor and scoreboard for the battery level estimator
module ble_level_checker import ble_pkg::*; #(
  parameter int WINDOW_LEN = 10,
  parameter int BLOCK_LEN  = 10
) (
  input  logic clk,
  input  logic rst_n,
  ble_in_if    in_mon,
  ble_out_if   out_mon,
  ble_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending_reports
);

  typedef struct packed {
    logic [PCT_W-1:0]   percent;
    logic [LEVEL_W-1:0] level;
  } report_t;

  report_t report_q[$];

  logic [GAIN_W-1:0]   gain;
  logic [OFFSET_W-1:0] offset;
  logic [THR_W-1:0]    thr;

  logic [31:0]        block_acc;
  int                 block_fill;
  logic [LEVEL_W-1:0] window_mem [WINDOW_LEN];
  int                 window_pos;
  logic [31:0]        window_acc;
  logic [LEVEL_W-1:0] last_level;

  function automatic logic [PCT_W-1:0] charge_percent(logic [LEVEL_W-1:0] lvl);
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    prod   = PROD_W'(gain) * PROD_W'(lvl);
    scaled = prod[PROD_W-1:GAIN_FRAC];
    if (scaled < offset) return '0;
    if (scaled - offset > SCALED_W'(PCT_MAX)) return PCT_MAX;
    return PCT_W'(scaled - offset);
  endfunction

  task automatic take_sample(logic [SAMPLE_W-1:0] s);
    logic [LEVEL_W-1:0] mean;
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] delta;
    block_acc  = block_acc + s;
    block_fill = block_fill + 1;
    if (block_fill < BLOCK_LEN) return;
    mean       = LEVEL_W'(block_acc / BLOCK_LEN);
    block_acc  = '0;
    block_fill = 0;
    // oldest block mean drops out of the running sum
    window_acc             = window_acc - window_mem[window_pos] + mean;
    window_mem[window_pos] = mean;
    window_pos             = (window_pos + 1) % WINDOW_LEN;
    lvl   = LEVEL_W'(window_acc / WINDOW_LEN);
    delta = (lvl > last_level) ? lvl - last_level : last_level - lvl;
    if (last_level == '0 || delta > thr)
      report_q.push_back(report_t'{charge_percent(lvl), lvl});
    // unscaled level kept whether or not a report goes out
    last_level = lvl;
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      gain       = GAIN_RST;
      offset     = OFFSET_RST;
      thr        = THR_RST;
      block_acc  = '0;
      block_fill = 0;
      window_pos = 0;
      window_acc = '0;
      last_level = '0;
      for (int i = 0; i < WINDOW_LEN; i++) window_mem[i] = '0;
      report_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (report_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected report: percent %0d level %0d", $time,
                     out_mon.percent, out_mon.filtered_level);
        end else begin
          want = report_q.pop_front();
          if (want.percent !== out_mon.percent || want.level !== out_mon.filtered_level) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t report mismatch: expected percent %0d level %0d, got %0d level %0d",
                       $time, want.percent, want.level, out_mon.percent,
                       out_mon.filtered_level);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SCALE_GAIN:   gain   = GAIN_W'(cfg_mon.data);
          CFG_EMPTY_OFFSET: offset = OFFSET_W'(cfg_mon.data);
          CFG_CHANGE_THR:   thr    = THR_W'(cfg_mon.data);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_sample(in_mon.sample);
    end
    pending_reports = report_q.size();
  end

endmodule

>>> tb/tb_battery_level_estimator.sv
// stimulus, handshake pacing and verdict for the battery level estimator
module tb_battery_level_estimator;
  import ble_pkg::*;

  localparam int WINDOW_LEN     = 10;
  localparam int BLOCK_LEN      = 10;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int DRAIN_CYCLES   = 16;
  localparam int END_CYCLES     = 40;
  localparam int LONG_HOLD      = 200;
  localparam int SAMPLE_TARGET  = 450;
  localparam int LIMIT_TIME     = 2000000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} rx_mode_t;
  typedef enum {BLK_ZERO, BLK_FULL, BLK_NOISE, BLK_NEAR} block_kind_t;
  typedef enum {SET_DEFAULT, SET_HOT, SET_COLD, SET_WILD, SET_FINE, SET_STEEP} setting_t;

  logic clk;
  logic rst_n;
  logic hold_request;

  ble_in_if  in_chan ();
  ble_out_if out_chan ();
  ble_cfg_if cfg_chan ();

  int level_fails;
  int reports_pending;
  int samples_sent;
  int reports_seen;
  int settings_used;
  int burst_left;
  int focus_level;
  bit steer;

  battery_level_estimator #(
    .WINDOW_LEN(WINDOW_LEN),
    .BLOCK_LEN (BLOCK_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  ble_level_checker #(
    .WINDOW_LEN(WINDOW_LEN),
    .BLOCK_LEN (BLOCK_LEN)
  ) level_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_mon        (cfg_chan),
    .fail_count     (level_fails),
    .pending_reports(reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("battery_level_estimator regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) reports_seen++;
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    out_chan.ready = 1'b0;
    mode      = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: out_chan.ready <= 1'b1;
          RX_MOSTLY: out_chan.ready <= ($urandom_range(0, 3) != 0);
          RX_RARELY: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default:   out_chan.ready <= !out_chan.ready;
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= s;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    burst_left--;
    samples_sent++;
  endtask

  // pipeline may still hold a block with no report once the queue is empty
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic feed_block(block_kind_t kind, int centre, int spread);
    int v;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      case (kind)
        BLK_ZERO:  v = 0;
        BLK_FULL:  v = SAMPLE_MAX;
        BLK_NOISE: v = int'($urandom_range(0, SAMPLE_MAX));
        default: begin
          v = centre + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end
      endcase
      send_sample(SAMPLE_W'(v));
    end
  endtask

  task automatic random_block();
    int r;
    r = $urandom_range(0, 11);
    if (steer && r >= 2)
      feed_block(BLK_NEAR, focus_level, $urandom_range(0, 300));
    else if (r < 2)
      feed_block(BLK_ZERO, 0, 0);
    else if (r == 2)
      feed_block(BLK_FULL, 0, 0);
    else if (r < 5)
      feed_block(BLK_NOISE, 0, 0);
    else
      feed_block(BLK_NEAR, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, 200));
  endtask

  task automatic apply_setting(setting_t s);
    logic [GAIN_W-1:0]     g;
    logic [OFFSET_W-1:0]   o;
    logic [THR_W-1:0]      t;
    logic [PROD_W-1:0]     prod;
    logic [CFG_DATA_W-1:0] word;
    int                    sc;
    steer = 1'b0;
    case (s)
      SET_DEFAULT: begin
        g = GAIN_RST;
        o = OFFSET_RST;
        t = THR_RST;
      end
      SET_HOT: begin
        g = '1;
        o = '0;
        t = '0;
      end
      SET_COLD: begin
        g = '0;
        o = '1;
        t = '1;
      end
      SET_WILD: begin
        g = GAIN_W'($urandom);
        o = OFFSET_W'($urandom);
        t = THR_W'($urandom_range(0, 60));
      end
      default: begin
        // offset placed just under the scaled focus level so percents spread over 0..100
        if (s == SET_FINE) g = GAIN_W'($urandom_range(16384, 65536));
        else g = GAIN_W'($urandom_range(65536, 262144));
        focus_level = $urandom_range(200, 3900);
        prod  = PROD_W'(g) * PROD_W'(focus_level);
        sc    = int'(prod >> GAIN_FRAC);
        o     = OFFSET_W'(sc - int'($urandom_range(0, (sc < 100) ? sc : 100)));
        t     = THR_W'($urandom_range(0, 12));
        steer = 1'b1;
      end
    endcase
    write_reg(CFG_SCALE_GAIN, CFG_DATA_W'(g));
    // upper bits beyond the register width carry junk
    word = CFG_DATA_W'($urandom);
    word[OFFSET_W-1:0] = o;
    write_reg(CFG_EMPTY_OFFSET, word);
    word = CFG_DATA_W'($urandom);
    word[THR_W-1:0] = t;
    write_reg(CFG_CHANGE_THR, word);
    if (s == SET_WILD) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  initial begin
    setting_t s;
    int       phase;
    rst_n           = 1'b0;
    hold_request    = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.sample  = '0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.index  = '0;
    cfg_chan.data   = '0;
    samples_sent    = 0;
    reports_seen    = 0;
    settings_used   = 0;
    burst_left      = 0;
    focus_level     = 0;
    steer           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-scale block from a zero previous level, then a zero block that leaves the level put
    feed_block(BLK_FULL, 0, 0);
    feed_block(BLK_ZERO, 0, 0);
    settle();

    phase = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      s = setting_t'(phase % 6);
      apply_setting(s);
      if (s == SET_HOT) hold_request <= 1'b1;
      case (s)
        SET_COLD: repeat (12) feed_block(BLK_ZERO, 0, 0);
        SET_FINE, SET_STEEP: repeat (10) random_block();
        default: repeat (5) random_block();
      endcase
      settle();
      phase++;
    end

    repeat (END_CYCLES) @(negedge clk);
    $display("%0d samples over %0d register settings, %0d reports checked, one %0d-cycle hold",
             samples_sent, settings_used, reports_seen, LONG_HOLD);
    if (level_fails == 0 && reports_pending == 0)
      $display("battery_level_estimator regression: pass");
    else
      $display("battery_level_estimator regression: fail");
    $finish;
  end

endmodule
